// ----- rtl/sb2da_pkg.sv -----
// Shared constants and the handoff type for the signed binary to decimal ASCII converter.
package sb2da_pkg;

   // Width of one BCD digit.
   localparam int DIGIT_BITS = 4;

   // Width of a digit count; covers the twenty digits of the widest word.
   localparam int LEN_BITS = 5;

   // ASCII codes that the emitter produces.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Control half of the handoff from the converter to the emitter.
   typedef struct packed {
      logic                valid;
      logic                neg;
      logic [LEN_BITS-1:0] digits;
   } conv_ctl_type;

endpackage

// ----- rtl/sb2da_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
interface sb2da_req_if #(
   parameter int WORD_BITS = 32
);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sb2da_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- rtl/sb2da_front.sv -----
// Front end: accepts request words and splits them into sign and unsigned magnitude.
module sb2da_front #(
   parameter int WORD_BITS = 32
) (
   sb2da_req_if.sink             req_ch,
   input  logic                  q_full,
   output logic                  q_push,
   output logic                  q_neg,
   output logic [WORD_BITS-1:0]  q_mag
);

   logic [WORD_BITS-1:0] raw;

   // Accept whenever the queue has room.
   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   // The magnitude is unsigned, so the most negative value maps to 2^(WORD_BITS-1).
   assign raw   = req_ch.value;
   assign q_neg = raw[WORD_BITS-1];
   assign q_mag = q_neg ? (~raw + {{(WORD_BITS-1){1'b0}}, 1'b1}) : raw;

endmodule

// ----- rtl/sb2da_queue.sv -----
// Two-entry queue of sign and magnitude between the front end and the converter.
module sb2da_queue #(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic                 push_neg,
   input  logic [WORD_BITS-1:0] push_mag,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output logic                 pop_neg,
   output logic [WORD_BITS-1:0] pop_mag
);

   logic [WORD_BITS:0] entry_ff [2];
   logic               wr_ptr_ff;
   logic               wr_ptr_in;
   logic               rd_ptr_ff;
   logic               rd_ptr_in;
   logic [1:0]         count_ff;
   logic [1:0]         count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;
   assign pop_neg   = entry_ff[rd_ptr_ff][WORD_BITS];
   assign pop_mag   = entry_ff[rd_ptr_ff][WORD_BITS-1:0];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= {push_neg, push_mag};
      end
   end

endmodule

// ----- rtl/sb2da_conv.sv -----
// Bit-serial binary to BCD converter using shift and add-three, one bit per cycle.
module sb2da_conv #(
   parameter int WORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  logic                         q_neg,
   input  logic [WORD_BITS-1:0]         q_mag,
   output logic                         q_pop,
   output sb2da_pkg::conv_ctl_type      ho,
   output logic [(WORD_BITS*3/10+1)*4-1:0] ho_bcd,
   input  logic                         ho_take
);

   localparam int NDIG  = WORD_BITS * 3 / 10 + 1;
   localparam int NB    = NDIG * sb2da_pkg::DIGIT_BITS;
   localparam int CNT_W = $clog2(WORD_BITS);

   typedef enum logic [2:0] {
      C_IDLE = 3'b001,
      C_RUN  = 3'b010,
      C_DONE = 3'b100
   } conv_state_type;

   conv_state_type               state_ff;
   conv_state_type               state_in;
   logic [WORD_BITS-1:0]         mag_ff;
   logic [WORD_BITS-1:0]         mag_in;
   logic [NB-1:0]                bcd_ff;
   logic [NB-1:0]                bcd_in;
   logic                         neg_ff;
   logic                         neg_in;
   logic [CNT_W-1:0]             cnt_ff;
   logic [CNT_W-1:0]             cnt_in;
   logic [NB-1:0]                bcd_adj;
   logic [sb2da_pkg::LEN_BITS-1:0] ndig;

   // Add three to every digit of five or more before the shift.
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   // Count of significant digits; zero still prints one digit.
   always_comb begin
      ndig = sb2da_pkg::LEN_BITS'(1);
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            ndig = sb2da_pkg::LEN_BITS'(i + 1);
         end
      end
   end

   // Sequencer: load a magnitude, shift in all WORD_BITS of its bits, then hand off.
   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      q_pop    = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               mag_in   = q_mag;
               bcd_in   = '0;
               neg_in   = q_neg;
               cnt_in   = '0;
               state_in = C_RUN;
            end
         end
         C_RUN: begin
            bcd_in = {bcd_adj[NB-2:0], mag_ff[WORD_BITS-1]};
            mag_in = {mag_ff[WORD_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + {{(CNT_W-1){1'b0}}, 1'b1};
            if (cnt_ff == CNT_W'(WORD_BITS - 1)) begin
               state_in = C_DONE;
            end
         end
         C_DONE: begin
            if (ho_take) begin
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign ho.valid  = (state_ff == C_DONE);
   assign ho.neg    = neg_ff;
   assign ho.digits = ndig;
   assign ho_bcd    = bcd_ff;

endmodule

// ----- rtl/sb2da_emit.sv -----
// Character emitter: sends the sign and the significant digits, one word per cycle while the receiver is ready.
module sb2da_emit #(
   parameter int WORD_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sb2da_pkg::conv_ctl_type         ho,
   input  logic [(WORD_BITS*3/10+1)*4-1:0] ho_bcd,
   output logic                            ho_take,
   sb2da_rsp_if.source                     rsp_ch,
   output logic                            busy
);

   localparam int NDIG  = WORD_BITS * 3 / 10 + 1;
   localparam int NB    = NDIG * sb2da_pkg::DIGIT_BITS;
   localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;

   logic                           busy_ff;
   logic                           busy_in;
   logic                           neg_ff;
   logic                           neg_in;
   logic [sb2da_pkg::LEN_BITS-1:0] left_ff;
   logic [sb2da_pkg::LEN_BITS-1:0] left_in;
   logic [NB-1:0]                  bcd_ff;
   logic [NB-1:0]                  bcd_in;
   logic [3:0]                     digs [NDIG];
   logic [IDX_W-1:0]               idx;
   logic                           fire;
   logic                           final_word;

   // Split the BCD word into digits.
   for (genvar g = 0; g < NDIG; g++) begin : g_dig
      assign digs[g] = bcd_ff[g*4 +: 4];
   end

   assign idx        = IDX_W'(left_ff - sb2da_pkg::LEN_BITS'(1));
   assign fire       = rsp_ch.valid && rsp_ch.ready;
   assign final_word = !neg_ff && (left_ff == sb2da_pkg::LEN_BITS'(1));
   assign ho_take    = ho.valid && !busy_ff;
   assign busy       = busy_ff;

   // Response payload.
   assign rsp_ch.valid     = busy_ff;
   assign rsp_ch.last      = final_word;
   assign rsp_ch.char_code = neg_ff ? sb2da_pkg::CHAR_MINUS
                                    : sb2da_pkg::CHAR_ZERO + {4'd0, digs[idx]};

   // Load a number when idle, then step through sign and digits.
   always_comb begin
      busy_in = busy_ff;
      neg_in  = neg_ff;
      left_in = left_ff;
      bcd_in  = bcd_ff;
      if (ho_take) begin
         busy_in = 1'b1;
         neg_in  = ho.neg;
         left_in = ho.digits;
         bcd_in  = ho_bcd;
      end else if (fire) begin
         if (neg_ff) begin
            neg_in = 1'b0;
         end else if (final_word) begin
            busy_in = 1'b0;
         end else begin
            left_in = left_ff - sb2da_pkg::LEN_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      left_ff <= left_in;
      bcd_ff  <= bcd_in;
   end

endmodule

// ----- rtl/signed_binary_to_decimal_ascii.sv -----
// Top level of the signed binary to decimal ASCII converter.
//
// The request channel carries one signed two's complement word per handshake.
// The response channel returns its decimal text as ASCII, one character per
// word, most significant first: a leading '-' for negative values, no leading
// zeros, a single '0' for zero, and last set on the final character.
// A front end splits each word into sign and magnitude and writes it to a
// two-entry queue. A bit-serial shift and add-three converter then converts
// each magnitude to BCD bit by bit, and an emitter sends the characters at one
// per cycle, while the receiver is ready, as the converter already works on the
// next number. The bit-serial converter limits how fast numbers pass, or the
// character count does when the receiver is slower. When the receiver holds
// ready low the current character waits, then the converter and the queue fill,
// and finally the request ready drops.
// Reset is synchronous and empties the queue and all control state; no
// clearing pass is needed.
module signed_binary_to_decimal_ascii #(
   parameter int WORD_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   sb2da_req_if.sink    req_ch,
   sb2da_rsp_if.source  rsp_ch
);

   localparam int NDIG = WORD_BITS * 3 / 10 + 1;
   localparam int NB   = NDIG * sb2da_pkg::DIGIT_BITS;

   logic                    q_push;
   logic                    q_full;
   logic                    f_neg;
   logic [WORD_BITS-1:0]    f_mag;
   logic                    q_pop;
   logic                    q_valid;
   logic                    q_neg;
   logic [WORD_BITS-1:0]    q_mag;
   sb2da_pkg::conv_ctl_type ho;
   logic [NB-1:0]           ho_bcd;
   logic                    ho_take;
   logic                    emit_busy;

   // Accept and classify.
   sb2da_front #(.WORD_BITS(WORD_BITS)) u_front (
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_neg  (f_neg),
      .q_mag  (f_mag)
   );

   // Decoupling queue.
   sb2da_queue #(.WORD_BITS(WORD_BITS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_neg  (f_neg),
      .push_mag  (f_mag),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_neg   (q_neg),
      .pop_mag   (q_mag)
   );

   // Binary to BCD conversion.
   sb2da_conv #(.WORD_BITS(WORD_BITS)) u_conv (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_neg   (q_neg),
      .q_mag   (q_mag),
      .q_pop   (q_pop),
      .ho      (ho),
      .ho_bcd  (ho_bcd),
      .ho_take (ho_take)
   );

   // Character output.
   sb2da_emit #(.WORD_BITS(WORD_BITS)) u_emit (
      .clock   (clock),
      .reset   (reset),
      .ho      (ho),
      .ho_bcd  (ho_bcd),
      .ho_take (ho_take),
      .rsp_ch  (rsp_ch),
      .busy    (emit_busy)
   );

`ifndef SYNTHESIS
   // A finished conversion always reports between one and NDIG digits.
   assert property (@(posedge clock) disable iff (reset)
      ho.valid |-> (ho.digits != '0) && (32'(ho.digits) <= NDIG))
      else $error("conversion reported a bad digit count");

   // A handoff to the emitter shows up as a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      ho_take |=> (rsp_ch.valid && emit_busy))
      else $error("handoff did not start a response");

   // The minus sign is never the final character of a number.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.char_code == sb2da_pkg::CHAR_MINUS)) |-> !rsp_ch.last)
      else $error("minus sign marked as last character");

   // An accepted request is held in the queue in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> q_valid)
      else $error("accepted request missing from queue");
`endif

endmodule
